/* hw/rtl/skl_pkg.sv */
package skl_pkg;

    // Field positions inside the security constant
    localparam int unsigned SelHiBit  = 11;
    localparam int unsigned SelLoBit  = 21;
    localparam int unsigned Sb1Lsb    = 2;
    localparam int unsigned Sb2Lsb    = 23;
    localparam int unsigned Sb3Lsb    = 13;
    localparam int unsigned SwapBit   = 0;

    localparam logic [7:0] Sb2Flip = 8'hA5;
    localparam logic [7:0] Sb3Flip = 8'h5A;

    // Feedback taps of the shift register
    localparam int unsigned TapA = 30;
    localparam int unsigned TapB = 24;
    localparam int unsigned TapC = 12;
    localparam int unsigned TapD = 2;

    localparam logic [1:0] SelByte3 = 2'd0;
    localparam logic [1:0] SelByte2 = 2'd1;
    localparam logic [1:0] SelByte1 = 2'd2;

    typedef enum logic [1:0] {
        SKL_IDLE,
        SKL_RUN,
        SKL_HOLD
    } skl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } skl_status_t;

    function automatic logic [7:0] pass_count(input logic [31:0] seed,
                                              input logic [31:0] sc);
        logic [1:0] sel;
        logic [7:0] b;
        logic [7:0] sb1;
        logic [7:0] sb2;
        logic [7:0] sb3;
        sel = {sc[SelHiBit], sc[SelLoBit]};
        case (sel)
            SelByte3: b = seed[31:24];
            SelByte2: b = seed[23:16];
            SelByte1: b = seed[15:8];
            default:  b = seed[7:0];
        endcase
        sb1 = sc[Sb1Lsb +: 8];
        sb2 = sc[Sb2Lsb +: 8] ^ Sb2Flip;
        sb3 = sc[Sb3Lsb +: 8] ^ Sb3Flip;
        // sum wraps at 8 bits
        return ((b ^ sb1) & sb2) + sb3;
    endfunction

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        return {s[30:0], s[TapA] ^ s[TapB] ^ s[TapC] ^ s[TapD]};
    endfunction

    function automatic logic [31:0] finish_key(input logic [31:0] s,
                                               input logic [31:0] sc);
        logic [31:0] r;
        r = sc[SwapBit] ? {s[15:8], s[31:24], s[7:0], s[23:16]} : s;
        return r ^ sc;
    endfunction

endpackage

/* hw/rtl/skl_lfsr_core.sv */
module skl_lfsr_core
    import skl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] seed,
    input  logic [7:0]  passes,
    input  logic        ack,
    output skl_status_t status,
    output logic [31:0] lfsr
);

    skl_state_t  state_reg, state_next;
    logic [31:0] lfsr_reg, lfsr_next;
    logic [7:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SKL_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        lfsr_reg <= lfsr_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        lfsr_next  = lfsr_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            SKL_IDLE: begin
                if (start) begin
                    lfsr_next  = seed;
                    cnt_next   = passes;
                    state_next = SKL_RUN;
                end
            end
            SKL_RUN: begin
                // advance one pass per cycle until the count runs out
                if (cnt_reg == 8'd0) begin
                    state_next = SKL_HOLD;
                end
                else begin
                    lfsr_next = lfsr_step(lfsr_reg);
                    cnt_next  = cnt_reg - 8'd1;
                end
            end
            SKL_HOLD: begin
                if (ack) begin
                    state_next = SKL_IDLE;
                end
            end
            default: begin
                state_next = SKL_IDLE;
            end
        endcase
    end

    assign status.busy = (state_reg != SKL_IDLE);
    assign status.done = (state_reg == SKL_HOLD);
    assign lfsr        = lfsr_reg;

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SKL_IDLE && start)
        |=> (state_reg == SKL_RUN && cnt_reg == $past(passes) && lfsr_reg == $past(seed)))
        else $error("core did not load the transaction");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SKL_RUN && cnt_reg != 8'd0)
        |=> (state_reg == SKL_RUN && cnt_reg == $past(cnt_reg) - 8'd1))
        else $error("pass count did not advance");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SKL_RUN && cnt_reg != 8'd0)
        |=> (lfsr_reg == lfsr_step($past(lfsr_reg))))
        else $error("shift register missed a pass");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SKL_HOLD && !ack)
        |=> (state_reg == SKL_HOLD && $stable(lfsr_reg)))
        else $error("finished value lost before hand-off");

endmodule

/* hw/rtl/seed_key_lfsr.sv */
// The accepting edge loads the seed and the pass count P (0..255), taken from the
// seed and the constant; the core runs P LFSR passes, one pass per cycle, and
// holds the result until the output slot is free; then the key is registered.
// The shift register serves one transaction at a time; a key may wait at output.
// Reset (rst_n low, asynchronous): security constant cleared to 0, no key pending,
// sequencer idle.
module seed_key_lfsr
    import skl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key
);

    logic [31:0] sc_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] key_reg, key_next;
    skl_status_t status;
    logic [31:0] lfsr;
    logic        start;
    logic        ack;

    assign in_stall = status.busy;
    assign start    = in_valid && !status.busy;
    // hand off when the output slot is empty or is being emptied
    assign ack      = status.done && (!out_valid_reg || !out_stall);

    skl_lfsr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .seed   (seed),
        .passes (pass_count(seed, sc_reg)),
        .ack    (ack),
        .status (status),
        .lfsr   (lfsr)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sc_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                sc_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        key_reg <= key_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        if (ack) begin
            out_valid_next = 1'b1;
            key_next       = finish_key(lfsr, sc_reg);
        end
        else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign key       = key_reg;

endmodule
